>>> rtl/core/cht_pkg.sv
package cht_pkg;

   localparam int MaxBuckets  = 16;
   localparam int ChainDepth  = 8;
   localparam int KeyW        = 31;
   localparam int BktW        = $clog2(MaxBuckets);
   localparam int SlotW       = $clog2(ChainDepth);
   localparam int LenW        = $clog2(ChainDepth + 1);
   localparam int AddrW       = BktW + SlotW;
   localparam int CntW        = 5;

   localparam logic [1:0] OpInsert = 2'd0;
   localparam logic [1:0] OpRemove = 2'd1;
   localparam logic [1:0] OpSearch = 2'd2;

   localparam logic [1:0] StDone    = 2'd0;
   localparam logic [1:0] StFull    = 2'd1;
   localparam logic [1:0] StMissing = 2'd2;

   localparam logic [1:0] RegBucketCount = 2'd0;
   localparam logic [1:0] RegHashMode    = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HASH,
      ST_INS,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_NEXT_BKT,
      ST_RESP
   } state_type;

   // hash unit start/finish handshake
   typedef struct packed {
      logic           start;
      logic           mode;
      logic [CntW-1:0] n;
   } hash_ctl_type;

   typedef struct packed {
      logic            done;
      logic [BktW-1:0] bucket;
   } hash_sts_type;

endpackage

>>> rtl/core/cht_hash.sv
// Iterative hash: modulo by restoring division against n shifted left, or decimal
// folding (one digit per cycle by reciprocal multiply for divide-by-ten, then
// divide-by-ten steps until below n).
module cht_hash import cht_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  hash_ctl_type        ctl,
   input  logic [KeyW-1:0]     key,
   output hash_sts_type        sts
);

   typedef enum logic [2:0] {
      H_IDLE, H_MOD, H_DIGIT, H_FOLD, H_DONE
   } hstate_type;

   hstate_type      hst_ff, hst_in;
   logic [KeyW-1:0] val_ff, val_in;   // remaining value / digit quotient
   logic [8:0]      sum_ff, sum_in;   // digit sum, at most 9*10
   logic [CntW-1:0] n_ff, n_in;
   logic [KeyW-1:0] mod_sub;          // modulo: shifted divisor
   logic [5:0]      sh_ff, sh_in;

   // modulo subtractor
   logic [KeyW:0]   diff;

   // divide by ten: multiply by 0xCCCCCCCD, keep bits 63:35
   logic [63:0]     prod;
   logic [KeyW-1:0] q10;
   logic [KeyW-1:0] q10x10;
   logic [3:0]      rem10;

   assign mod_sub = KeyW'({26'd0, n_ff} << sh_ff);
   assign diff    = {1'b0, val_ff} - {1'b0, mod_sub};

   assign prod   = 64'(val_ff) * 64'h0000_0000_CCCC_CCCD;
   assign q10    = KeyW'(prod[63:35]);
   assign q10x10 = (q10 << 3) + (q10 << 1);
   assign rem10  = 4'(val_ff - q10x10);

   always_comb begin
      hst_in = hst_ff;
      val_in = val_ff;
      sum_in = sum_ff;
      n_in   = n_ff;
      sh_in  = sh_ff;
      unique case (hst_ff)
         H_IDLE: begin
            if (ctl.start) begin
               val_in = key;
               sum_in = '0;
               n_in   = ctl.n;
               sh_in  = 6'(KeyW - 1);
               hst_in = ctl.mode ? H_DIGIT : H_MOD;
            end
         end
         // restoring long division, one bit per cycle
         H_MOD: begin
            if (!diff[KeyW] && ({26'd0, n_ff} << sh_ff) >> sh_ff == {26'd0, n_ff})
               val_in = diff[KeyW-1:0];
            if (sh_ff == 6'd0) hst_in = H_DONE;
            else sh_in = sh_ff - 6'd1;
         end
         // digit extraction: one decimal digit a cycle
         H_DIGIT: begin
            sum_in = sum_ff + 9'(rem10);
            val_in = q10;
            if (q10 == '0) begin
               val_in = KeyW'(sum_ff + 9'(rem10));
               hst_in = H_FOLD;
            end
         end
         // fold: divide by ten until below n
         H_FOLD: begin
            if (val_ff < KeyW'(n_ff)) hst_in = H_DONE;
            else val_in = q10;
         end
         H_DONE: hst_in = H_IDLE;
         default: hst_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hst_ff <= H_IDLE;
      end else begin
         hst_ff <= hst_in;
      end
      val_ff <= val_in;
      sum_ff <= sum_in;
      n_ff   <= n_in;
      sh_ff  <= sh_in;
   end

   assign sts.done   = (hst_ff == H_DONE);
   assign sts.bucket = val_ff[BktW-1:0];

endmodule

>>> rtl/core/cht_store.sv
// Key store: one write port, one registered read port.
module cht_store import cht_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [KeyW-1:0]  wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [KeyW-1:0]  rd_data
);

   logic [KeyW-1:0] mem [2**AddrW];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/core/chained_hash_table.sv
// Channel  | Direction | Ports
// request  | in        | req_valid, req_stall, req_op, req_key
// response | out       | rsp_valid, rsp_stall, rsp_status, rsp_bucket, rsp_found
// config   | in/out    | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One word at a time. Insert: hash the key by modulo, or by digit folding with
// divide-by-ten steps, then write it at the end of its bucket's chain.
// Search/remove: scan the buckets in use, comparing each stored key; remove also
// moves the later keys of a chain down. The response word is then held until taken.
// Reset clears chain lengths and registers; the key store is not cleared.
// req_stall is high from acceptance until the response word is taken.
module chained_hash_table import cht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [30:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_bucket,
   output logic        rsp_found,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   state_type        st_ff, st_in;
   logic [CntW-1:0]  bcount_ff;
   logic             hmode_ff;
   logic [LenW-1:0]  len_ff [MaxBuckets];
   logic [1:0]       op_ff;
   logic [KeyW-1:0]  key_ff;
   logic [BktW-1:0]  bkt_ff, bkt_in;
   logic [SlotW:0]   idx_ff, idx_in;
   logic [1:0]       status_ff, status_in;
   logic [BktW-1:0]  obkt_ff, obkt_in;
   logic             found_ff, found_in;
   logic [CntW-1:0]  n_act;
   logic [LenW-1:0]  cur_len;
   logic             accept;
   logic             wr_en;
   logic [AddrW-1:0] wr_addr, rd_addr;
   logic [KeyW-1:0]  wr_data, rd_data;
   logic             len_wr;
   logic [LenW-1:0]  len_wdata;
   logic             last_bkt;
   hash_ctl_type     hctl;
   hash_sts_type     hsts;

   // register file
   assign pready = 1'b1;
   always_comb begin
      unique case (paddr[2])
         1'b0:    prdata = {27'd0, bcount_ff};
         default: prdata = {31'd0, hmode_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcount_ff <= CntW'(10);
         hmode_ff  <= 1'b0;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == RegBucketCount[0]) bcount_ff <= pwdata[CntW-1:0];
         else if (paddr[2] == RegHashMode[0]) hmode_ff <= pwdata[0];
      end
   end

   assign n_act = (bcount_ff == '0) ? CntW'(1) :
                  (bcount_ff > CntW'(MaxBuckets)) ? CntW'(MaxBuckets) : bcount_ff;
   assign cur_len  = len_ff[bkt_ff];
   assign last_bkt = ({1'b0, bkt_ff} + 5'd1 >= n_act);
   assign accept   = req_valid && !req_stall;
   assign req_stall = (st_ff != ST_IDLE);
   assign rsp_valid = (st_ff == ST_RESP);
   assign rsp_status = status_ff;
   assign rsp_bucket = obkt_ff;
   assign rsp_found  = found_ff;

   assign hctl.start = (st_ff == ST_HASH) && !hsts.done && (idx_ff == '0);
   assign hctl.mode  = hmode_ff;
   assign hctl.n     = n_act;

   cht_hash u_hash (
      .clock (clock),
      .reset (reset),
      .ctl   (hctl),
      .key   (key_ff),
      .sts   (hsts)
   );

   cht_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OpInsert: st_in = ST_HASH;
                  OpRemove, OpSearch: st_in = ST_SCAN_RD;
                  default: st_in = ST_RESP;
               endcase
            end
         end
         ST_HASH:     if (hsts.done) st_in = ST_INS;
         ST_INS:      st_in = ST_RESP;
         ST_SCAN_RD: begin
            if (idx_ff >= (SlotW+1)'(cur_len)) st_in = ST_NEXT_BKT;
            else st_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (rd_data == key_ff) begin
               if (op_ff == OpSearch) st_in = ST_RESP;
               else st_in = ST_SHIFT_RD;
            end else begin
               st_in = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (idx_ff + 1'b1 >= (SlotW+1)'(cur_len)) st_in = ST_NEXT_BKT;
            else st_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: st_in = ST_SHIFT_RD;
         ST_NEXT_BKT: st_in = last_bkt ? ST_RESP : ST_SCAN_RD;
         ST_RESP:     if (!rsp_stall) st_in = ST_IDLE;
         default:     st_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      bkt_in    = bkt_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      obkt_in   = obkt_ff;
      found_in  = found_ff;
      wr_en     = 1'b0;
      wr_addr   = {bkt_ff, idx_ff[SlotW-1:0]};
      wr_data   = key_ff;
      rd_addr   = {bkt_ff, idx_ff[SlotW-1:0]};
      len_wr    = 1'b0;
      len_wdata = cur_len;
      unique case (st_ff)
         ST_IDLE: begin
            bkt_in    = '0;
            idx_in    = '0;
            status_in = (req_op == OpSearch) ? StMissing : StDone;
            obkt_in   = '0;
            found_in  = 1'b0;
         end
         ST_HASH: begin
            idx_in = (SlotW+1)'(1);
            if (hsts.done) bkt_in = hsts.bucket;
         end
         ST_INS: begin
            obkt_in = bkt_ff;
            wr_addr = {bkt_ff, cur_len[SlotW-1:0]};
            if (cur_len >= LenW'(ChainDepth)) begin
               status_in = StFull;
            end else begin
               wr_en     = 1'b1;
               len_wr    = 1'b1;
               len_wdata = cur_len + 1'b1;
            end
         end
         ST_SCAN_CMP: begin
            if (rd_data == key_ff) begin
               found_in = 1'b1;
               if (op_ff == OpSearch) begin
                  status_in = StDone;
                  obkt_in   = bkt_ff;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         // read next entry, written one place down next cycle; at chain end, shorten the chain
         ST_SHIFT_RD: begin
            rd_addr = {bkt_ff, idx_ff[SlotW-1:0] + 1'b1};
            if (idx_ff + 1'b1 >= (SlotW+1)'(cur_len)) begin
               len_wr    = 1'b1;
               len_wdata = cur_len - 1'b1;
            end
         end
         ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            idx_in  = idx_ff + 1'b1;
         end
         ST_NEXT_BKT: begin
            bkt_in = bkt_ff + 1'b1;
            idx_in = '0;
            if (last_bkt && op_ff == OpRemove)
               status_in = found_ff ? StDone : StMissing;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         for (int i = 0; i < MaxBuckets; i++) len_ff[i] <= '0;
      end else begin
         st_ff <= st_in;
         if (len_wr) len_ff[bkt_ff] <= len_wdata;
      end
      if (accept) begin
         op_ff  <= req_op;
         key_ff <= req_key;
      end
      bkt_ff    <= bkt_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      obkt_ff   <= obkt_in;
      found_ff  <= found_in;
   end

endmodule

>>> dv/tb_chained_hash_table.sv
module tb_chained_hash_table;
   import cht_pkg::*;

   typedef struct packed {
      logic [1:0]  op;
      logic [30:0] key;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] bucket;
      logic       found;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = '0;
   logic [30:0] req_key = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_bucket;
   logic        rsp_found;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   chained_hash_table uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow of the table
   logic [30:0] shadow_keys [MaxBuckets][ChainDepth];
   int unsigned shadow_len [MaxBuckets];
   int unsigned cfg_buckets;
   logic        cfg_fold;

   req_word_type pending_words[$];
   rsp_word_type expected_rsp[$];
   int          errors = 0;
   int          words_sent = 0;
   int          rsp_seen = 0;
   int          full_seen = 0;
   int          hit_seen = 0;
   bit          driver_hold = 1'b0;
   bit          in_taken = 1'b0;
   bit          rsp_taken = 1'b0;
   int unsigned drv_wait = 0;
   int unsigned rsp_wait = 0;

   task automatic report(input string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   function automatic int unsigned live_buckets();
      if (cfg_buckets < 1) return 1;
      if (cfg_buckets > MaxBuckets) return MaxBuckets;
      return cfg_buckets;
   endfunction

   function automatic int unsigned bucket_of(input logic [30:0] key, input int unsigned n);
      int unsigned k;
      int unsigned sum;
      k = key;
      sum = 0;
      if (!cfg_fold) return k % n;
      while (k > 0) begin
         sum += k % 10;
         k /= 10;
      end
      while (sum >= n) sum /= 10;
      return sum;
   endfunction

   // applies one word to the shadow and returns the response it should produce
   function automatic rsp_word_type table_apply(input req_word_type w);
      rsp_word_type r;
      int unsigned n;
      int unsigned b;
      int unsigned i;
      int unsigned j;
      bit hit;
      n = live_buckets();
      r = '0;
      if (w.op == OpInsert) begin
         b = bucket_of(w.key, n);
         r.bucket = b[3:0];
         if (shadow_len[b] >= ChainDepth) r.status = StFull;
         else begin
            shadow_keys[b][shadow_len[b]] = w.key;
            shadow_len[b]++;
         end
      end else if (w.op == OpRemove) begin
         for (b = 0; b < n; b++) begin
            hit = 1'b0;
            for (i = 0; i < shadow_len[b] && !hit; i++)
               if (shadow_keys[b][i] == w.key) begin
                  hit = 1'b1;
                  for (j = i; j + 1 < shadow_len[b]; j++)
                     shadow_keys[b][j] = shadow_keys[b][j+1];
                  shadow_len[b]--;
                  r.found = 1'b1;
               end
         end
         r.status = r.found ? StDone : StMissing;
      end else if (w.op == OpSearch) begin
         r.status = StMissing;
         for (b = 0; b < n && !r.found; b++)
            for (i = 0; i < shadow_len[b]; i++)
               if (shadow_keys[b][i] == w.key && !r.found) begin
                  r.status = StDone;
                  r.bucket = b[3:0];
                  r.found = 1'b1;
               end
      end
      return r;
   endfunction

   // input acceptance: the shadow is updated with the word taken at this edge
   always @(posedge clock) begin
      req_word_type w;
      in_taken = !reset && req_valid && !req_stall;
      if (in_taken) begin
         w.op  = req_op;
         w.key = req_key;
         expected_rsp.push_back(table_apply(w));
         words_sent++;
      end
   end

   // driver: one word at a time from the pending queue, random gaps
   always @(negedge clock) begin
      req_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         drv_wait  <= 0;
      end else if (req_valid) begin
         if (in_taken) begin
            req_valid <= 1'b0;
            req_op    <= 2'($urandom_range(0, 3));
            req_key   <= 31'($urandom);
            if ($urandom_range(0, 3) == 0) drv_wait <= 0;
            else drv_wait <= $urandom_range(0, 12);
         end
      end else if (drv_wait > 0) begin
         drv_wait <= drv_wait - 1;
      end else if (!driver_hold && pending_words.size() > 0) begin
         w = pending_words.pop_front();
         req_op    <= w.op;
         req_key   <= w.key;
         req_valid <= 1'b1;
      end
   end

   // receiver: a fresh number of stall cycles for every response word
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  <= $urandom_range(0, 12);
      end else if (rsp_taken) begin
         rsp_stall <= 1'b0;
         rsp_wait  <= $urandom_range(0, 12);
      end else if (rsp_valid && rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait  <= rsp_wait - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: compare each taken response with the oldest expectation
   always @(posedge clock) begin
      rsp_word_type want;
      rsp_taken = !reset && rsp_valid && !rsp_stall;
      if (rsp_taken) begin
         rsp_seen++;
         if (expected_rsp.size() == 0) report("response with nothing expected");
         else begin
            want = expected_rsp.pop_front();
            if (rsp_status != want.status)
               report($sformatf("status %0d want %0d", rsp_status, want.status));
            if (rsp_bucket != want.bucket)
               report($sformatf("bucket %0d want %0d", rsp_bucket, want.bucket));
            if (rsp_found != want.found)
               report($sformatf("found %0d want %0d", rsp_found, want.found));
            if (want.status == StFull) full_seen++;
            if (want.found) hit_seen++;
         end
      end
   end

   task automatic wait_drained();
      while (pending_words.size() > 0 || expected_rsp.size() > 0 || req_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 1'b0} << 1; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx == RegBucketCount) cfg_buckets = value[4:0];
      else if (idx == RegHashMode) cfg_fold = value[0];
   endtask

   function automatic logic [30:0] pick_key();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 31'h7FFF_FFFF;
         2: return 31'($urandom);
         default: return 31'($urandom_range(0, 40));
      endcase
   endfunction

   task automatic queue_word(input logic [1:0] op, input logic [30:0] key);
      req_word_type w;
      w.op = op;
      w.key = key;
      pending_words.push_back(w);
   endtask

   initial begin : stimulus
      int phase;
      int k;
      int unsigned settings [6] = '{10, 1, 16, 0, 31, 5};
      for (int b = 0; b < MaxBuckets; b++) shadow_len[b] = 0;
      cfg_buckets = 10;
      cfg_fold = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, each op, unused op, full bucket, duplicates
      queue_word(OpSearch, 31'd5);
      queue_word(OpRemove, 31'd5);
      queue_word(OpInsert, 31'h7FFF_FFFF);
      queue_word(OpInsert, 31'd0);
      queue_word(OpSearch, 31'h7FFF_FFFF);
      queue_word(2'd3, 31'h5555_5555);
      for (k = 0; k < 9; k++) queue_word(OpInsert, 31'(10 * k + 3));
      queue_word(OpInsert, 31'd3);
      queue_word(OpRemove, 31'd3);
      queue_word(OpRemove, 31'd13);
      queue_word(OpSearch, 31'd23);
      queue_word(OpRemove, 31'h7FFF_FFFF);
      wait_drained();

      // random phases over several settings, duplicates of live keys common
      for (phase = 0; phase < 12; phase++) begin
         csr_write(RegBucketCount, (phase < 6) ? settings[phase] : $urandom_range(0, 31));
         csr_write(RegHashMode, (phase == 0) ? 1 : $urandom_range(0, 1));
         for (k = 0; k < 85; k++)
            queue_word(($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                       pick_key());
         if (phase == 4) begin
            // sender holds off until all answers are back
            while (pending_words.size() > 40) @(posedge clock);
            driver_hold = 1'b1;
            while (expected_rsp.size() > 0 || req_valid) @(posedge clock);
            driver_hold = 1'b0;
         end
         wait_drained();
      end

      $display("Covered %0d words, %0d responses (%0d bucket-full, %0d hits), 12 settings",
               words_sent, rsp_seen, full_seen, hit_seen);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin : watchdog
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
